@@ rtl/hcbd_pkg.sv @@
// Package for the HTTP chunked body decoder.
// Holds the parse phase type, character codes and byte classifiers.
// No dependencies.
package hcbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int TRAIL_LEN = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LC  = 8'h78;
  localparam logic [7:0] CH_X_UC  = 8'h58;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_HEX,
    PH_DIGITS,
    PH_DATA,
    PH_TRAIL,
    PH_DONE
  } phase_t;

  // Hex digit value; 16 means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

@@ rtl/http_chunked_body_decoder.sv @@
// HTTP chunked transfer decoder, top level.
// Parses chunk size lines and passes chunk data; depends on hcbd_pkg.
//
//   channel  direction  signals
//   in       sink       in_valid, in_ready, in_byte, in_last
//   out      source     out_valid, out_ready, data_byte, has_data, body_end, end_status
//
// One item per cycle while the output is not stalled: an input register feeds the byte
// decode and state update, which writes the result register when the item advances.
// Reset clears the parse state and both valid flags.
// A stalled result register holds only items that produce a result; items that
// produce none drain from the input register even while the output is stalled.
module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       has_data,
  output logic       body_end,
  output logic       end_status
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // parse state
  phase_t                 phase, phase_next;
  logic [SIZE_BITS-1:0]   size_accum, size_accum_next;
  logic [SIZE_BITS-1:0]   bytes_left, bytes_left_next;
  logic [1:0]             trailer_skip, trailer_skip_next;
  logic                   fl_stop, fl_stop_next;
  logic                   fl_neg, fl_neg_next;
  logic                   fl_cr, fl_cr_next;

  logic       emit, r_has, r_end, r_status;
  logic       s1_adv;
  logic [4:0] dval;
  logic       take_first;
  logic       terminated;
  logic [SIZE_BITS-1:0] size_val;
  logic [SIZE_BITS-1:0] bl_dec;
  logic [1:0]           sk_dec;

  assign dval   = hex_value(s1_byte);
  assign bl_dec = bytes_left - SIZE_BITS'(bytes_left != '0);
  assign sk_dec = trailer_skip - 2'(trailer_skip != 2'd0);
  assign size_val = fl_neg ? '0 : size_accum;

  always_comb begin
    phase_next        = phase;
    size_accum_next   = size_accum;
    bytes_left_next   = bytes_left;
    trailer_skip_next = trailer_skip;
    fl_stop_next      = fl_stop;
    fl_neg_next       = fl_neg;
    fl_cr_next        = fl_cr;
    emit       = 1'b0;
    r_has      = 1'b0;
    r_end      = 1'b0;
    r_status   = 1'b0;
    take_first = 1'b0;
    terminated = 1'b0;

    if (phase == PH_DONE) begin
      // ignore bytes until the last mark
    end else if (phase == PH_DATA) begin
      emit  = 1'b1;
      r_has = 1'b1;
      bytes_left_next = bl_dec;
      if (bl_dec == '0) begin
        phase_next        = PH_TRAIL;
        trailer_skip_next = 2'(TRAIL_LEN);
      end
    end else if (phase == PH_TRAIL) begin
      trailer_skip_next = sk_dec;
      if (sk_dec == 2'd0) begin
        phase_next      = PH_LEAD;
        size_accum_next = '0;
        fl_stop_next    = 1'b0;
        fl_neg_next     = 1'b0;
        fl_cr_next      = 1'b0;
      end
    end else if (fl_cr && s1_byte == CH_LF) begin
      size_accum_next = '0;
      fl_stop_next    = 1'b0;
      fl_neg_next     = 1'b0;
      fl_cr_next      = 1'b0;
      if (size_val == '0) begin
        phase_next = PH_DONE;
        terminated = 1'b1;
        r_end      = 1'b1;
        emit       = 1'b1;
      end else begin
        phase_next      = PH_DATA;
        bytes_left_next = size_val;
      end
    end else begin
      if (!fl_stop) begin
        unique case (phase)
          PH_LEAD: begin
            if (is_blank(s1_byte)) begin
            end else if (s1_byte == CH_PLUS) begin
              phase_next = PH_SIGNED;
            end else if (s1_byte == CH_MINUS) begin
              fl_neg_next = 1'b1;
              phase_next  = PH_SIGNED;
            end else begin
              take_first = 1'b1;
            end
          end
          PH_SIGNED: take_first = 1'b1;
          PH_ZERO: begin
            if (s1_byte == CH_X_LC || s1_byte == CH_X_UC) begin
              phase_next = PH_HEX;
            end else if (dval < 5'd16) begin
              size_accum_next = SIZE_BITS'(dval[3:0]);
              phase_next      = PH_DIGITS;
            end else begin
              fl_stop_next = 1'b1;
            end
          end
          PH_HEX: begin
            if (dval < 5'd16) begin
              size_accum_next = SIZE_BITS'(dval[3:0]);
              phase_next      = PH_DIGITS;
            end else begin
              fl_stop_next = 1'b1;
            end
          end
          default: begin
            if (dval < 5'd16) begin
              // saturate once the top nibble would shift out
              if (|size_accum[SIZE_BITS-1 -: 4]) size_accum_next = '1;
              else size_accum_next = {size_accum[SIZE_BITS-5:0], dval[3:0]};
            end else begin
              fl_stop_next = 1'b1;
            end
          end
        endcase
        if (take_first) begin
          if (s1_byte == CH_ZERO) begin
            phase_next = PH_ZERO;
          end else if (dval < 5'd16) begin
            size_accum_next = SIZE_BITS'(dval[3:0]);
            phase_next      = PH_DIGITS;
          end else begin
            fl_stop_next = 1'b1;
          end
        end
      end
      fl_cr_next = (s1_byte == CH_CR);
    end

    if (s1_last) begin
      if (!terminated && phase != PH_DONE) begin
        r_end    = 1'b1;
        r_status = 1'b1;
        emit     = 1'b1;
      end
      phase_next        = PH_LEAD;
      size_accum_next   = '0;
      bytes_left_next   = '0;
      trailer_skip_next = 2'd0;
      fl_stop_next      = 1'b0;
      fl_neg_next       = 1'b0;
      fl_cr_next        = 1'b0;
    end
  end

  // an item with no result moves on even while the output is stalled
  assign s1_adv   = s1_valid && (!out_valid || out_ready || !emit);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      size_accum   <= '0;
      bytes_left   <= '0;
      trailer_skip <= 2'd0;
      fl_stop      <= 1'b0;
      fl_neg       <= 1'b0;
      fl_cr        <= 1'b0;
    end else if (s1_adv) begin
      phase        <= phase_next;
      size_accum   <= size_accum_next;
      bytes_left   <= bytes_left_next;
      trailer_skip <= trailer_skip_next;
      fl_stop      <= fl_stop_next;
      fl_neg       <= fl_neg_next;
      fl_cr        <= fl_cr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && emit) begin
      data_byte  <= r_has ? s1_byte : 8'h00;
      has_data   <= r_has;
      body_end   <= r_end;
      end_status <= r_status;
    end
  end

`ifndef SYNTH
  a_data_phase_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with no bytes left");

  a_trail_phase_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAIL |-> trailer_skip != 2'd0)
    else $error("trailer phase with nothing to skip");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> body_end)
    else $error("result carries neither data nor end of body");

  a_data_end_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data && body_end |-> end_status)
    else $error("data byte with a normal end of body");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_byte) && $stable(phase))
    else $error("stalled input item lost or state moved");
`endif

endmodule

@@ test/http_chunked_body_decoder_test.sv @@
// Testbench for http_chunked_body_decoder: drives chunked bodies and checks decoded items.
// A scoreboard class predicts each result from the accepted input bytes.
// Depends on hcbd_pkg and the decoder RTL only.
module http_chunked_body_decoder_test;
  import hcbd_pkg::*;

  localparam logic [63:0] SIZE_TOP = (64'd1 << SIZE_BITS) - 64'd1;
  localparam int unsigned ITEM_TARGET = 1400;
  localparam int unsigned MAX_SHOWN = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
    logic       status;
  } decoded_t;

  class body_decoder_scoreboard;
    decoded_t    expected_q[$];
    phase_t      ph;
    logic [63:0] acc;
    logic [63:0] left;
    bit          got_digit, stopped, negative, saw_cr;
    int unsigned skip;
    int unsigned failures, shown, items, results, data_bytes, completions, early_ends;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      ph = PH_LEAD;
      acc = '0;
      left = '0;
      got_digit = 0;
      stopped = 0;
      negative = 0;
      saw_cr = 0;
      skip = 0;
    endfunction

    function int unsigned digit_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return 16;
    endfunction

    function bit blank(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // Saturating base-16 accumulate.
    function logic [63:0] grow(logic [63:0] a, int unsigned d);
      if (a > (SIZE_TOP - 64'(d)) / 64'd16) return SIZE_TOP;
      return a * 64'd16 + 64'(d);
    endfunction

    function void begin_number(logic [7:0] b, int unsigned d);
      if (b == CH_ZERO) begin
        got_digit = 1;
        ph = PH_ZERO;
      end else if (d < 16) begin
        got_digit = 1;
        acc = 64'(d);
        ph = PH_DIGITS;
      end else begin
        stopped = 1;
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      int unsigned d;
      d = digit_of(b);
      case (ph)
        PH_LEAD: begin
          if (blank(b)) begin
          end else if (b == CH_PLUS) begin
            ph = PH_SIGNED;
          end else if (b == CH_MINUS) begin
            negative = 1;
            ph = PH_SIGNED;
          end else begin
            begin_number(b, d);
          end
        end
        PH_SIGNED: begin_number(b, d);
        PH_ZERO: begin
          if (b == CH_X_LC || b == CH_X_UC) begin
            ph = PH_HEX;
          end else if (d < 16) begin
            acc = 64'(d);
            ph = PH_DIGITS;
          end else begin
            stopped = 1;
          end
        end
        PH_HEX: begin
          if (d < 16) begin
            acc = 64'(d);
            ph = PH_DIGITS;
          end else begin
            stopped = 1;
          end
        end
        default: begin
          if (d < 16) acc = grow(acc, d);
          else stopped = 1;
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic last);
      decoded_t    r;
      bit          emit, term;
      logic [63:0] size;
      r = '0;
      emit = 0;
      term = 0;
      items++;
      if (ph == PH_DONE) begin
        if (last) clear_state();
        return;
      end else if (ph == PH_DATA) begin
        r.data = b;
        r.has = 1;
        emit = 1;
        if (left > 0) left--;
        if (left == 0) begin
          ph = PH_TRAIL;
          skip = TRAIL_LEN;
        end
      end else if (ph == PH_TRAIL) begin
        if (skip > 0) skip--;
        if (skip == 0) begin
          ph = PH_LEAD;
          acc = '0;
          got_digit = 0;
          stopped = 0;
          negative = 0;
          saw_cr = 0;
        end
      end else if (saw_cr && b == CH_LF) begin
        size = negative ? 64'd0 : (acc & SIZE_TOP);
        acc = '0;
        got_digit = 0;
        stopped = 0;
        negative = 0;
        saw_cr = 0;
        if (size == 0) begin
          ph = PH_DONE;
          term = 1;
          r.fin = 1;
          emit = 1;
        end else begin
          ph = PH_DATA;
          left = size;
        end
      end else begin
        if (!stopped) parse_byte(b);
        saw_cr = (b == CH_CR);
      end
      if (last) begin
        if (!term) begin
          r.fin = 1;
          r.status = 1;
          emit = 1;
        end
        clear_state();
      end
      if (emit) begin
        expected_q.push_back(r);
        results++;
        if (r.has) data_bytes++;
        if (r.fin && !r.status) completions++;
        if (r.status) early_ends++;
      end
    endfunction

    function void mismatch(string field, int unsigned e, int unsigned a);
      failures++;
      if (shown < MAX_SHOWN) $display("%0t: %s expected %0h got %0h", $time, field, e, a);
      shown++;
    endfunction

    function void check_result(decoded_t got);
      decoded_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        if (shown < MAX_SHOWN)
          $display("%0t: unexpected result, expected none got %0h", $time, got);
        shown++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.data !== exp.data) mismatch("data_byte", exp.data, got.data);
      if (got.has !== exp.has) mismatch("has_data", exp.has, got.has);
      if (got.fin !== exp.fin) mismatch("body_end", exp.fin, got.fin);
      if (got.status !== exp.status) mismatch("end_status", exp.status, got.status);
    endfunction

    function void drain_check();
      if (expected_q.size() > 0) begin
        failures += expected_q.size();
        $display("%0t: %0d expected results never arrived, expected %0h got none",
                 $time, expected_q.size(), expected_q[0]);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       has_data;
  logic       body_end;
  logic       end_status;

  body_decoder_scoreboard sb;
  logic [7:0]  body_q[$];
  bit          idle_on = 1'b1;
  int unsigned items_sent, bodies_sent;

  http_chunked_body_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .data_byte(data_byte),
    .has_data(has_data), .body_end(body_end), .end_status(end_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Handshakes are sampled mid-cycle, where inputs and outputs are stable.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_byte, in_last);
      if (out_valid && out_ready)
        sb.check_result(decoded_t'({data_byte, has_data, body_end, end_status}));
    end
  end

  initial begin
    int unsigned gap;
    @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!(out_valid && !rst)) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout: decoder stopped making progress");
    $display("Test completed with failures");
    $finish;
  end

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void put_line(string s);
    put_str(s);
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
  endfunction

  // Sends body_q, one item per byte, with the last mark on its final byte.
  task automatic send_body();
    int unsigned gap;
    for (int i = 0; i < body_q.size(); i++) begin
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte <= body_q[i];
      in_last <= (i == body_q.size() - 1);
      @(negedge clk);
      while (!in_ready) @(negedge clk);
      @(posedge clk);
      items_sent++;
    end
    bodies_sent++;
    body_q.delete();
  endtask

  // Well-formed chunks with random formatting and content, sometimes cut short.
  function automatic void build_good_body();
    int unsigned n_chunks, size, cut;
    string       hex, blanks, ends;
    blanks = " \t\v\f";
    n_chunks = $urandom_range(0, 3);
    for (int c = 0; c < n_chunks; c++) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
        body_q.push_back(blanks[$urandom_range(0, 3)]);
      if ($urandom_range(0, 5) == 0) put_str("+");
      if ($urandom_range(0, 4) == 0) put_str($urandom_range(0, 1) ? "0x" : "0X");
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_str("0");
      hex = $sformatf("%0h", size);
      if ($urandom_range(0, 1)) hex = hex.toupper();
      put_str(hex);
      if ($urandom_range(0, 3) == 0) begin
        put_str(";");
        repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
      put_line("");
      repeat (size) body_q.push_back(8'($urandom));
      if ($urandom_range(0, 6) == 0) repeat (2) body_q.push_back(8'($urandom));
      else put_line("");
    end
    ends = "0";
    case ($urandom_range(0, 5))
      0: ends = "00";
      1: ends = "+0";
      2: ends = "0x0";
      3: ends = "0X";
      4: ends = " 0;last";
      default: ends = "0";
    endcase
    put_line(ends);
    if ($urandom_range(0, 1)) put_line("");
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom));
    if ($urandom_range(0, 4) == 0 && body_q.size() > 1) begin
      cut = $urandom_range(1, body_q.size() - 1);
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
  endfunction

  // Malformed or odd size lines, oversized sizes, stray bytes.
  function automatic void build_broken_body();
    string junk, digits;
    junk = "0123456789aAfFgxX+- \t;";
    digits = "0123456789abcdefABCDEF";
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1)) put_str("1");
        repeat ($urandom_range(8, 11)) body_q.push_back(digits[$urandom_range(0, 21)]);
      end else begin
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 9))
            0: body_q.push_back(8'($urandom));
            1: body_q.push_back(CH_CR);
            2: body_q.push_back(CH_LF);
            default: body_q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
          endcase
        end
      end
      put_line("");
      repeat ($urandom_range(0, 10)) body_q.push_back(8'($urandom));
    end
  endfunction

  initial begin
    int unsigned kind, w;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // negative size ends the body; a stray byte then carries the last mark
    put_line("-5");
    put_str("Z");
    send_body();
    // blanks and sign, one 0xFF data byte, then a blank line as missing size
    put_line(" \t+1");
    body_q.push_back(8'hFF);
    put_line("");
    put_line("");
    send_body();
    // saturated size, stream cut on a data byte
    put_line("1FfFfFfFf");
    body_q.push_back(8'h00);
    send_body();
    // lone CR inside the line, then a "0x" terminator on the last byte
    put_str("1");
    body_q.push_back(CH_CR);
    put_line("2");
    body_q.push_back(8'h80);
    put_line("");
    put_line("0x");
    send_body();

    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_good_body();
      end else if (kind < 85) begin
        build_broken_body();
      end else begin
        repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom));
      end
      send_body();
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    for (w = 0; w < 20000 && sb.expected_q.size() > 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.drain_check();

    $display("Drove %0d bytes in %0d bodies; checked %0d results: %0d payload bytes,",
             items_sent, bodies_sent, sb.results, sb.data_bytes);
    $display("%0d clean completions and %0d truncated bodies", sb.completions, sb.early_ends);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
